// ===== hw/rtl/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int ByteW      = 8;
  localparam int CodeW      = 21;
  localparam int PendW      = 2;
  localparam int FifoDepth  = 4;
  localparam int FifoAw     = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
  localparam logic [ByteW-1:0] Lead2Lo    = 8'hc2;
  localparam logic [ByteW-1:0] Lead2Hi    = 8'hdf;
  localparam logic [ByteW-1:0] Lead3Lo    = 8'he0;
  localparam logic [ByteW-1:0] Lead3Hi    = 8'hef;
  localparam logic [ByteW-1:0] Lead4Lo    = 8'hf0;
  localparam logic [ByteW-1:0] Lead4Hi    = 8'hf4;
  localparam logic [ByteW-1:0] Mask2      = 8'h1f;
  localparam logic [ByteW-1:0] Mask3      = 8'h0f;
  localparam logic [ByteW-1:0] Mask4      = 8'h07;
  localparam logic [ByteW-1:0] MaskCont   = 8'h3f;
  localparam logic [ByteW-1:0] NulByte    = 8'h00;

  localparam logic [PendW-1:0] PendNone   = 2'd0;
  localparam logic [PendW-1:0] PendOne    = 2'd1;
  localparam logic [PendW-1:0] PendTwo    = 2'd2;
  localparam logic [PendW-1:0] PendThree  = 2'd3;

  localparam logic [1:0] WrNone = 2'd0;
  localparam logic [1:0] WrOne  = 2'd1;
  localparam logic [1:0] WrTwo  = 2'd2;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             truncated;
    logic             string_end;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } wr_t;

  typedef struct packed {
    logic room;
  } fifo_status_t;

endpackage

// ===== hw/rtl/u8d_byte_if.sv =====
// ----------------------------------------------------------------------------
// u8d_byte_if
// Byte channel of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== hw/rtl/u8d_code_if.sv =====
// ----------------------------------------------------------------------------
// u8d_code_if
// Code point channel of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
interface u8d_code_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::CodeW-1:0] code_point;
  logic                      truncated;
  logic                      string_end;

  modport source (output valid, output code_point, output truncated, output string_end,
                  input ready);
  modport sink   (input valid, input code_point, input truncated, input string_end,
                  output ready);
endinterface

// ===== hw/rtl/u8d_decode.sv =====
// ----------------------------------------------------------------------------
// u8d_decode
// Input register, decoder state and the per-byte decode into result writes.
// ----------------------------------------------------------------------------
module u8d_decode (
  input  logic                  clk,
  input  logic                  rst,
  u8d_byte_if.sink              bytes,
  input  u8d_pkg::fifo_status_t status,
  output u8d_pkg::wr_t          wr
);

  logic                              valid_q;
  logic [u8d_pkg::ByteW-1:0]         byte_q;
  logic [u8d_pkg::PendW-1:0]         pending;
  logic [u8d_pkg::PendW-1:0]         pending_next;
  logic [u8d_pkg::CodeW-1:0]         partial;
  logic [u8d_pkg::CodeW-1:0]         partial_next;
  logic [u8d_pkg::CodeW-1:0]         cont_code;
  logic [u8d_pkg::CodeW-1:0]         byte_code;
  logic                              advance;
  u8d_pkg::wr_t                      wr_raw;

  assign advance     = valid_q && status.room;
  assign bytes.ready = !valid_q || status.room;

  assign cont_code = {partial[u8d_pkg::CodeW-7:0], byte_q[5:0]};
  assign byte_code = {{(u8d_pkg::CodeW-u8d_pkg::ByteW){1'b0}}, byte_q};

  always_comb begin
    wr_raw       = '0;
    pending_next = pending;
    partial_next = partial;
    if (byte_q == u8d_pkg::NulByte) begin
      pending_next = u8d_pkg::PendNone;
      partial_next = '0;
      if (pending != u8d_pkg::PendNone) begin
        wr_raw.count  = u8d_pkg::WrTwo;
        wr_raw.first  = '{code_point: partial, truncated: 1'b1, string_end: 1'b0};
        wr_raw.second = '{code_point: '0, truncated: 1'b0, string_end: 1'b1};
      end else begin
        wr_raw.count = u8d_pkg::WrOne;
        wr_raw.first = '{code_point: '0, truncated: 1'b0, string_end: 1'b1};
      end
    end else if (pending != u8d_pkg::PendNone) begin
      pending_next = pending - u8d_pkg::PendOne;
      if (pending == u8d_pkg::PendOne) begin
        wr_raw.count = u8d_pkg::WrOne;
        wr_raw.first = '{code_point: cont_code, truncated: 1'b0, string_end: 1'b0};
        partial_next = '0;
      end else begin
        partial_next = cont_code;
      end
    end else if (byte_q < u8d_pkg::AsciiLimit) begin
      wr_raw.count = u8d_pkg::WrOne;
      wr_raw.first = '{code_point: byte_code, truncated: 1'b0, string_end: 1'b0};
    end else if (byte_q >= u8d_pkg::Lead2Lo && byte_q <= u8d_pkg::Lead2Hi) begin
      pending_next = u8d_pkg::PendOne;
      partial_next = {{(u8d_pkg::CodeW-u8d_pkg::ByteW){1'b0}}, byte_q & u8d_pkg::Mask2};
    end else if (byte_q >= u8d_pkg::Lead3Lo && byte_q <= u8d_pkg::Lead3Hi) begin
      pending_next = u8d_pkg::PendTwo;
      partial_next = {{(u8d_pkg::CodeW-u8d_pkg::ByteW){1'b0}}, byte_q & u8d_pkg::Mask3};
    end else if (byte_q >= u8d_pkg::Lead4Lo && byte_q <= u8d_pkg::Lead4Hi) begin
      pending_next = u8d_pkg::PendThree;
      partial_next = {{(u8d_pkg::CodeW-u8d_pkg::ByteW){1'b0}}, byte_q & u8d_pkg::Mask4};
    end else begin
      wr_raw.count = u8d_pkg::WrOne;
      wr_raw.first = '{code_point: byte_code, truncated: 1'b0, string_end: 1'b0};
    end
  end

  always_comb begin
    wr = wr_raw;
    if (!advance) begin
      wr.count = u8d_pkg::WrNone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      pending <= u8d_pkg::PendNone;
      partial <= '0;
    end else begin
      if (advance) begin
        pending <= pending_next;
        partial <= partial_next;
      end
      if (bytes.ready) begin
        valid_q <= bytes.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      byte_q <= bytes.byte_in;
    end
  end

  a_write_has_room: assert property (@(posedge clk) disable iff (rst)
    (wr.count != u8d_pkg::WrNone) |-> status.room)
    else $error("result write without room");

  a_pair_is_trunc_then_end: assert property (@(posedge clk) disable iff (rst)
    (wr.count == u8d_pkg::WrTwo) |->
      (wr.first.truncated && !wr.first.string_end && wr.second.string_end))
    else $error("result pair out of order");

  a_nul_clears_state: assert property (@(posedge clk) disable iff (rst)
    (advance && byte_q == u8d_pkg::NulByte) |=>
      (pending == u8d_pkg::PendNone && partial == '0))
    else $error("state not cleared after terminator");

endmodule

// ===== hw/rtl/u8d_result_fifo.sv =====
// ----------------------------------------------------------------------------
// u8d_result_fifo
// Result queue: takes up to two results a cycle, hands one out a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module u8d_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  u8d_pkg::wr_t          wr,
  output u8d_pkg::fifo_status_t status,
  u8d_code_if.source            codes
);

  u8d_pkg::result_t                  mem [u8d_pkg::FifoDepth];
  logic [u8d_pkg::FifoAw-1:0]        wr_ptr;
  logic [u8d_pkg::FifoAw-1:0]        rd_ptr;
  logic [u8d_pkg::FifoAw-1:0]        wr_ptr_1;
  logic [u8d_pkg::FifoCntW-1:0]      count;
  logic [u8d_pkg::FifoCntW-1:0]      count_next;
  logic                              pop;
  u8d_pkg::result_t                  head;

  assign wr_ptr_1    = wr_ptr + 1'b1;
  assign pop         = codes.valid && codes.ready;
  assign status.room = count <= u8d_pkg::FifoCntW'(u8d_pkg::FifoDepth - 2);

  assign head             = mem[rd_ptr];
  assign codes.valid      = count != '0;
  assign codes.code_point = head.code_point;
  assign codes.truncated  = head.truncated;
  assign codes.string_end = head.string_end;

  assign count_next = count + u8d_pkg::FifoCntW'(wr.count) - u8d_pkg::FifoCntW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + u8d_pkg::FifoAw'(wr.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.count != u8d_pkg::WrNone) begin
      mem[wr_ptr] <= wr.first;
    end
    if (wr.count == u8d_pkg::WrTwo) begin
      mem[wr_ptr_1] <= wr.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= u8d_pkg::FifoCntW'(u8d_pkg::FifoDepth))
    else $error("result queue overflow");

  a_count_tracks_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count != u8d_pkg::FifoCntW'(u8d_pkg::FifoDepth)) |->
      (wr_ptr - rd_ptr == u8d_pkg::FifoAw'(count)))
    else $error("queue count and pointers disagree");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count_next)))
    else $error("queue count update lost");

endmodule

// ===== hw/rtl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a NUL-terminated UTF-8 byte stream into code point results.
//
// bytes: one string byte per request (byte_in); a zero byte ends the string.
// codes: one result per request (code_point, truncated, string_end).
// A byte is taken into an input register, decoded from there and its
// results written into a four-entry result queue, whose head drives codes.
// Throughput: one byte per cycle while the queue has room; a zero byte that
// cuts a character short yields two results, which leave the queue in turn.
// The input is ready whenever the input register is empty or the queue has
// room for two results, so a stalled receiver holds bytes back only once
// the queue holds more than two results; nothing is dropped.
// Reset clears the input register, the queue and the pending character;
// the first byte after reset, or after a terminator, starts a new string.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  u8d_byte_if.sink   bytes,
  u8d_code_if.source codes
);

  u8d_pkg::wr_t          wr;
  u8d_pkg::fifo_status_t status;

  u8d_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .status (status),
    .wr     (wr)
  );

  u8d_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .status (status),
    .codes  (codes)
  );

endmodule

// ===== tb/utf8_stream_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_tb
// Streams NUL-terminated byte strings into the decoder and checks every code
// point result, in order, against a cycle-free decoder kept in the bench.
// Covers field extremes, invalid lead bytes, lead-like continuations, strings
// cut short mid-character, random well-formed and broken strings under three
// idling mixes, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int TailCycles  = 8;
  localparam int MaxPrinted  = 20;

  bit clk = 1'b0;
  logic rst;

  u8d_byte_if byte_ch ();
  u8d_code_if code_ch ();

  utf8_stream_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .codes (code_ch)
  );

  u8d_pkg::result_t          expected_codes [$];
  logic [u8d_pkg::PendW-1:0] pend_bytes = u8d_pkg::PendNone;
  logic [u8d_pkg::CodeW-1:0] code_acc   = '0;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_len     = 0;
  int hold_req     = 0;
  int hold_done    = 0;
  int hold_left    = 0;

  int sent_bytes    = 0;
  int strings_done  = 0;
  int cut_chars     = 0;
  int results_seen  = 0;
  int err_count     = 0;
  int cycle_count   = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_codes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void push_code(input logic [u8d_pkg::CodeW-1:0] code, input logic cut,
                                    input logic last);
    u8d_pkg::result_t r;
    r.code_point = code;
    r.truncated  = cut;
    r.string_end = last;
    expected_codes.push_back(r);
  endfunction

  function automatic void decode_byte(input logic [u8d_pkg::ByteW-1:0] b);
    if (b == u8d_pkg::NulByte) begin
      if (pend_bytes != u8d_pkg::PendNone) push_code(code_acc, 1'b1, 1'b0);
      push_code('0, 1'b0, 1'b1);
      pend_bytes = u8d_pkg::PendNone;
      code_acc   = '0;
    end else if (pend_bytes != u8d_pkg::PendNone) begin
      code_acc   = {code_acc[u8d_pkg::CodeW-7:0], b[5:0]};
      pend_bytes = pend_bytes - u8d_pkg::PendOne;
      if (pend_bytes == u8d_pkg::PendNone) begin
        push_code(code_acc, 1'b0, 1'b0);
        code_acc = '0;
      end
    end else if (b < u8d_pkg::AsciiLimit) begin
      push_code(u8d_pkg::CodeW'(b), 1'b0, 1'b0);
    end else if (b >= u8d_pkg::Lead2Lo && b <= u8d_pkg::Lead2Hi) begin
      pend_bytes = u8d_pkg::PendOne;
      code_acc   = u8d_pkg::CodeW'(b & u8d_pkg::Mask2);
    end else if (b >= u8d_pkg::Lead3Lo && b <= u8d_pkg::Lead3Hi) begin
      pend_bytes = u8d_pkg::PendTwo;
      code_acc   = u8d_pkg::CodeW'(b & u8d_pkg::Mask3);
    end else if (b >= u8d_pkg::Lead4Lo && b <= u8d_pkg::Lead4Hi) begin
      pend_bytes = u8d_pkg::PendThree;
      code_acc   = u8d_pkg::CodeW'(b & u8d_pkg::Mask4);
    end else begin
      push_code(u8d_pkg::CodeW'(b), 1'b0, 1'b0);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MaxPrinted)
      $display("%0t: mismatch on %s after %0d results: got %0h, expected %0h",
               $realtime, what, results_seen, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : check_codes
    u8d_pkg::result_t want;
    if (!rst && code_ch.valid && code_ch.ready) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected result", 32'(code_ch.code_point), '0);
      end else begin
        want = expected_codes.pop_front();
        if (code_ch.code_point !== want.code_point)
          report_mismatch("code_point", 32'(code_ch.code_point), 32'(want.code_point));
        if (code_ch.truncated !== want.truncated)
          report_mismatch("truncated", 32'(code_ch.truncated), 32'(want.truncated));
        if (code_ch.string_end !== want.string_end)
          report_mismatch("string_end", 32'(code_ch.string_end), 32'(want.string_end));
        if (want.string_end) strings_done++;
        if (want.truncated) cut_chars++;
      end
      results_seen++;
    end
  end

  always @(negedge clk) begin
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      code_ch.ready <= 1'b0;
    end else begin
      code_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic send_byte(input logic [u8d_pkg::ByteW-1:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < snd_idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.byte_in <= b;
    do @(posedge clk); while (!byte_ch.ready);
    decode_byte(b);
    sent_bytes++;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_codes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [u8d_pkg::ByteW-1:0] cont_byte();
    if ($urandom_range(0, 99) < 85) return 8'h80 | 8'($urandom_range(0, 63));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_char(input bit cut);
    int len;
    int keep;
    len = cut ? $urandom_range(2, 4) : $urandom_range(1, 4);
    case (len)
      1: send_byte(8'($urandom_range(1, u8d_pkg::AsciiLimit - 1)));
      2: send_byte(8'($urandom_range(u8d_pkg::Lead2Lo, u8d_pkg::Lead2Hi)));
      3: send_byte(8'($urandom_range(u8d_pkg::Lead3Lo, u8d_pkg::Lead3Hi)));
      default: send_byte(8'($urandom_range(u8d_pkg::Lead4Lo, u8d_pkg::Lead4Hi)));
    endcase
    keep = cut ? $urandom_range(0, len - 2) : len - 1;
    repeat (keep) send_byte(cont_byte());
  endtask

  task automatic send_random_string();
    int nchars;
    int pick;
    nchars = $urandom_range(0, 10);
    for (int i = 0; i < nchars; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        send_char(1'b0);
      end else if (pick < 93) begin
        send_byte(8'($urandom_range(1, 255)));
      end else begin
        send_char(1'b1);
        break;
      end
    end
    send_byte(u8d_pkg::NulByte);
  endtask

  task automatic run_random(input int target, input int snd_pct, input int rcv_pct);
    int start;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = sent_bytes;
    while (sent_bytes - start < target) send_random_string();
  endtask

  task automatic test_directed();
    logic [u8d_pkg::ByteW-1:0] seq [23] = '{
      u8d_pkg::NulByte, 8'h01, 8'h7f, 8'h80, 8'hc1, 8'hf5, 8'hff,
      8'hc2, 8'h80, 8'hdf, 8'hbf,
      8'he0, 8'hc2, 8'hff,
      8'hf4, 8'h8f, 8'hbf, 8'hbf,
      8'hf0, u8d_pkg::NulByte,
      8'hef, 8'hbf, u8d_pkg::NulByte
    };
    snd_idle_pct = 12;
    rcv_idle_pct = 81;
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_sender_light_idle();
    run_random(330, 12, 81);
  endtask

  task automatic test_receiver_light_idle();
    run_random(330, 81, 12);
  endtask

  task automatic test_no_idle();
    run_random(280, 0, 0);
  endtask

  task automatic test_receiver_hold();
    int start;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_len = 120;
    hold_req++;
    start = sent_bytes;
    while (sent_bytes - start < 60) send_random_string();
  endtask

  task automatic test_drain_pause();
    snd_idle_pct = 30;
    rcv_idle_pct = 30;
    repeat (3) send_random_string();
    idle_sender();
    wait_drained();
    repeat (3) send_random_string();
  endtask

  initial begin
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.byte_in = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_sender_light_idle();
    test_receiver_light_idle();
    test_no_idle();
    test_receiver_hold();
    test_drain_pause();

    idle_sender();
    wait_drained();
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d bytes in %0d strings; checked %0d results, %0d of them truncated.",
             sent_bytes, strings_done, results_seen, cut_chars);
    $display("Idling mixes, a %0d-cycle receiver hold-off and a drain pause were run.",
             hold_len);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_byte_if.sv
hw/rtl/u8d_code_if.sv
hw/rtl/u8d_decode.sv
hw/rtl/u8d_result_fifo.sv
hw/rtl/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
